### design/hue_rotate_pixel_macros.svh
`ifndef HUE_ROTATE_PIXEL_MACROS_SVH
`define HUE_ROTATE_PIXEL_MACROS_SVH

// same-cycle implication on the block clock, quiet during reset
`define HRP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on the block clock, quiet during reset
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### design/hrp_pkg.sv
package hrp_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int HUE_W        = 15;
   localparam int FIX_BITS     = 16;
   localparam int QUO_W        = FIX_BITS + 1;
   localparam int REM_W        = 12;

   localparam logic [HUE_W-1:0] HUE_SIXTH = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
   localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;
   localparam logic [HUE_W:0]   HUE_TWICE = 16'd46080;

   // floor(x * 2^16 / 3840) for x < 3840 is (x * RECIP_15) >> 16
   localparam logic [20:0] RECIP_15 = 21'd1118482;
   localparam logic [FIX_BITS:0] ONE_FIX = 17'd65536;

   typedef enum logic [1:0] {
      BASE_RED,
      BASE_GREEN,
      BASE_BLUE
   } base_type;

   typedef enum logic [2:0] {
      SEC_0,
      SEC_1,
      SEC_2,
      SEC_3,
      SEC_4,
      SEC_5
   } sector_type;

   typedef struct packed {
      logic     grey;
      base_type base;
      logic     neg;
   } hue_ctrl_type;

endpackage

### design/hrp_hsv.sv
module hrp_hsv #(
   parameter int CHANNEL_BITS = hrp_pkg::CHANNEL_BITS
) (
   input  logic                                       clock,
   input  logic                                       en,
   input  logic [CHANNEL_BITS-1:0]                    red,
   input  logic [CHANNEL_BITS-1:0]                    green,
   input  logic [CHANNEL_BITS-1:0]                    blue,
   input  logic [CHANNEL_BITS-1:0]                    alpha,
   output logic [CHANNEL_BITS-1:0]                    v_ff,
   output logic [CHANNEL_BITS-1:0]                    alpha_ff,
   output hrp_pkg::hue_ctrl_type                      ctrl_ff,
   output logic [CHANNEL_BITS+hrp_pkg::FIX_BITS-1:0]  s_num_ff,
   output logic [CHANNEL_BITS-1:0]                    s_den_ff,
   output logic [CHANNEL_BITS+hrp_pkg::FIX_BITS-1:0]  h_num_ff,
   output logic [CHANNEL_BITS-1:0]                    h_den_ff
);

   localparam int NUM_W = CHANNEL_BITS + hrp_pkg::FIX_BITS;

   logic [CHANNEL_BITS-1:0] mx, mn, delta, ha, hb, dmag;
   hrp_pkg::hue_ctrl_type   ctrl_in;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;
      // ties go to red, then green
      if (red == mx) begin
         ctrl_in.base = hrp_pkg::BASE_RED;
         ha = green;
         hb = blue;
      end else if (green == mx) begin
         ctrl_in.base = hrp_pkg::BASE_GREEN;
         ha = blue;
         hb = red;
      end else begin
         ctrl_in.base = hrp_pkg::BASE_BLUE;
         ha = red;
         hb = green;
      end
      ctrl_in.neg  = ha < hb;
      ctrl_in.grey = delta == '0;
      dmag = ctrl_in.neg ? hb - ha : ha - hb;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff     <= mx;
         alpha_ff <= alpha;
         ctrl_ff  <= ctrl_in;
         s_num_ff <= {delta, {hrp_pkg::FIX_BITS{1'b0}}};
         // 3840 * d as 4096 * d - 256 * d
         h_num_ff <= (NUM_W'(dmag) << 12) - (NUM_W'(dmag) << 8);
         s_den_ff <= ctrl_in.grey ? CHANNEL_BITS'(1) : mx;
         h_den_ff <= ctrl_in.grey ? CHANNEL_BITS'(1) : delta;
      end
   end

endmodule

### design/hrp_div.sv
module hrp_div #(
   parameter int DEN_W = hrp_pkg::CHANNEL_BITS,
   parameter int QUO_W = hrp_pkg::QUO_W
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [DEN_W+QUO_W-2:0]   num,
   input  logic [DEN_W-1:0]         den,
   output logic [QUO_W-1:0]         quo
);

   // dividend top bits start as the partial remainder; quotient must fit QUO_W
   localparam int NUM_W = DEN_W + QUO_W - 1;

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [DEN_W-1:0] rem_prev, den_prev;
      logic [QUO_W-1:0] low_prev, quo_prev;
      logic [DEN_W:0]   trial;
      logic             fit;

      if (i == 0) begin : g_first
         assign rem_prev = {1'b0, num[NUM_W-1:QUO_W]};
         assign den_prev = den;
         assign low_prev = num[QUO_W-1:0];
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign low_prev = low_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign trial = {rem_prev, low_prev[QUO_W-1]};
      assign fit   = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= fit ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
            den_ff[i] <= den_prev;
            low_ff[i] <= {low_prev[QUO_W-2:0], 1'b0};
            quo_ff[i] <= {quo_prev[QUO_W-2:0], fit};
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

### design/hrp_rgb.sv
module hrp_rgb #(
   parameter int CHANNEL_BITS = hrp_pkg::CHANNEL_BITS
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic [hrp_pkg::HUE_W-1:0]     hue_offset,
   input  logic [CHANNEL_BITS-1:0]       v,
   input  logic [CHANNEL_BITS-1:0]       alpha,
   input  hrp_pkg::hue_ctrl_type         ctrl,
   input  logic [hrp_pkg::QUO_W-1:0]     s_quo,
   input  logic [hrp_pkg::QUO_W-1:0]     h_quo,
   output logic [CHANNEL_BITS-1:0]       red_ff,
   output logic [CHANNEL_BITS-1:0]       green_ff,
   output logic [CHANNEL_BITS-1:0]       blue_ff,
   output logic [CHANNEL_BITS-1:0]       alpha_ff
);

   localparam int HW = hrp_pkg::HUE_W;
   localparam int FB = hrp_pkg::FIX_BITS;
   localparam int PW = CHANNEL_BITS + FB + 1;

   // hue wrap stage
   logic [HW:0]             hsum;
   logic [HW-1:0]           hbase, mag, hue_in;
   logic [HW-1:0]           hue_ff;
   logic [CHANNEL_BITS-1:0] v1_ff, a1_ff;
   logic                    g1_ff;
   logic [FB:0]             s1_ff;

   always_comb begin
      mag = HW'(h_quo);
      case (ctrl.base)
         hrp_pkg::BASE_GREEN: hbase = ctrl.neg ? hrp_pkg::HUE_GREEN - mag
                                               : hrp_pkg::HUE_GREEN + mag;
         hrp_pkg::BASE_BLUE:  hbase = ctrl.neg ? hrp_pkg::HUE_BLUE - mag
                                               : hrp_pkg::HUE_BLUE + mag;
         default:             hbase = ctrl.neg ? hrp_pkg::HUE_FULL - mag : mag;
      endcase
      if (ctrl.grey) hbase = '0;
      hsum = {1'b0, hbase} + {1'b0, hue_offset};
      if (hsum >= hrp_pkg::HUE_TWICE)
         hue_in = HW'(hsum - hrp_pkg::HUE_TWICE);
      else if (hsum >= {1'b0, hrp_pkg::HUE_FULL})
         hue_in = HW'(hsum - {1'b0, hrp_pkg::HUE_FULL});
      else
         hue_in = hsum[HW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue_ff <= hue_in;
         v1_ff  <= v;
         a1_ff  <= alpha;
         g1_ff  <= ctrl.grey;
         s1_ff  <= s_quo;
      end
   end

   // sector split stage
   hrp_pkg::sector_type         sec_in, sec2_ff;
   logic [hrp_pkg::REM_W-1:0]   rem_in, rem2_ff;
   logic [HW-1:0]               sec_base;
   logic [CHANNEL_BITS-1:0]     v2_ff, a2_ff;
   logic                        g2_ff;
   logic [FB:0]                 s2_ff;

   always_comb begin
      if (hue_ff >= 5 * hrp_pkg::HUE_SIXTH) begin
         sec_in = hrp_pkg::SEC_5;
         sec_base = HW'(5 * hrp_pkg::HUE_SIXTH);
      end else if (hue_ff >= 4 * hrp_pkg::HUE_SIXTH) begin
         sec_in = hrp_pkg::SEC_4;
         sec_base = HW'(4 * hrp_pkg::HUE_SIXTH);
      end else if (hue_ff >= 3 * hrp_pkg::HUE_SIXTH) begin
         sec_in = hrp_pkg::SEC_3;
         sec_base = HW'(3 * hrp_pkg::HUE_SIXTH);
      end else if (hue_ff >= 2 * hrp_pkg::HUE_SIXTH) begin
         sec_in = hrp_pkg::SEC_2;
         sec_base = HW'(2 * hrp_pkg::HUE_SIXTH);
      end else if (hue_ff >= hrp_pkg::HUE_SIXTH) begin
         sec_in = hrp_pkg::SEC_1;
         sec_base = hrp_pkg::HUE_SIXTH;
      end else begin
         sec_in = hrp_pkg::SEC_0;
         sec_base = '0;
      end
      rem_in = hrp_pkg::REM_W'(hue_ff - sec_base);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sec2_ff <= sec_in;
         rem2_ff <= rem_in;
         v2_ff   <= v1_ff;
         a2_ff   <= a1_ff;
         g2_ff   <= g1_ff;
         s2_ff   <= s1_ff;
      end
   end

   // fraction stage
   logic [32:0]                 frac_prod;
   logic [FB-1:0]               frac3_ff;
   hrp_pkg::sector_type         sec3_ff;
   logic [CHANNEL_BITS-1:0]     v3_ff, a3_ff;
   logic                        g3_ff;
   logic [FB:0]                 s3_ff;

   assign frac_prod = 33'(rem2_ff) * 33'(hrp_pkg::RECIP_15);

   always_ff @(posedge clock) begin
      if (en) begin
         frac3_ff <= frac_prod[FB+FB-1:FB];
         sec3_ff  <= sec2_ff;
         v3_ff    <= v2_ff;
         a3_ff    <= a2_ff;
         g3_ff    <= g2_ff;
         s3_ff    <= s2_ff;
      end
   end

   // saturation scaling stage
   logic [2*FB+1:0]             sf_prod, sq_prod;
   logic [FB:0]                 fo4_ff, fp4_ff, fq4_ff;
   hrp_pkg::sector_type         sec4_ff;
   logic [CHANNEL_BITS-1:0]     v4_ff, a4_ff;
   logic                        g4_ff;

   assign sf_prod = (2*FB+2)'(s3_ff) * (2*FB+2)'(frac3_ff);
   assign sq_prod = (2*FB+2)'(s3_ff) * (2*FB+2)'(hrp_pkg::ONE_FIX - {1'b0, frac3_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         fo4_ff  <= hrp_pkg::ONE_FIX - s3_ff;
         fp4_ff  <= hrp_pkg::ONE_FIX - sf_prod[2*FB:FB];
         fq4_ff  <= hrp_pkg::ONE_FIX - sq_prod[2*FB:FB];
         sec4_ff <= sec3_ff;
         v4_ff   <= v3_ff;
         a4_ff   <= a3_ff;
         g4_ff   <= g3_ff;
      end
   end

   // value products stage
   logic [PW-1:0]               po5_ff, pp5_ff, pq5_ff;
   hrp_pkg::sector_type         sec5_ff;
   logic [CHANNEL_BITS-1:0]     v5_ff, a5_ff;
   logic                        g5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         po5_ff  <= PW'(v4_ff) * PW'(fo4_ff);
         pp5_ff  <= PW'(v4_ff) * PW'(fp4_ff);
         pq5_ff  <= PW'(v4_ff) * PW'(fq4_ff);
         sec5_ff <= sec4_ff;
         v5_ff   <= v4_ff;
         a5_ff   <= a4_ff;
         g5_ff   <= g4_ff;
      end
   end

   // rounding and sector select into the output register
   logic [PW-1:0]           ro_sum, rp_sum, rq_sum;
   logic [CHANNEL_BITS-1:0] ch_o, ch_p, ch_q;
   logic [CHANNEL_BITS-1:0] red_in, green_in, blue_in;

   always_comb begin
      ro_sum = po5_ff + PW'(1 << (FB - 1));
      rp_sum = pp5_ff + PW'(1 << (FB - 1));
      rq_sum = pq5_ff + PW'(1 << (FB - 1));
      ch_o = ro_sum[FB+CHANNEL_BITS-1:FB];
      ch_p = rp_sum[FB+CHANNEL_BITS-1:FB];
      ch_q = rq_sum[FB+CHANNEL_BITS-1:FB];
      case (sec5_ff)
         hrp_pkg::SEC_1: begin red_in = ch_p;  green_in = v5_ff; blue_in = ch_o;  end
         hrp_pkg::SEC_2: begin red_in = ch_o;  green_in = v5_ff; blue_in = ch_q;  end
         hrp_pkg::SEC_3: begin red_in = ch_o;  green_in = ch_p;  blue_in = v5_ff; end
         hrp_pkg::SEC_4: begin red_in = ch_q;  green_in = ch_o;  blue_in = v5_ff; end
         hrp_pkg::SEC_5: begin red_in = v5_ff; green_in = ch_o;  blue_in = ch_p;  end
         default:        begin red_in = v5_ff; green_in = ch_q;  blue_in = ch_o;  end
      endcase
      if (g5_ff) begin
         red_in   = v5_ff;
         green_in = v5_ff;
         blue_in  = v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= a5_ff;
      end
   end

endmodule

### design/hue_rotate_pixel.sv
// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_stall  | red, green, blue, alpha in
// rsp      | out       | rsp_valid/rsp_stall  | red, green, blue, alpha out
// csr      | in        | csr_wr_en            | hue_offset
//
// one pixel per clock while not stalled; the pipeline is the 17 one-bit stages of
// the saturation and hue dividers plus one front stage and six back stages
// reset clears every valid bit and the hue offset; data registers are not reset
// a stalled result holds the whole pipeline; req_stall = rsp_valid && rsp_stall
module hue_rotate_pixel #(
   parameter int CHANNEL_BITS = hrp_pkg::CHANNEL_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [CHANNEL_BITS-1:0]       req_red_in,
   input  logic [CHANNEL_BITS-1:0]       req_green_in,
   input  logic [CHANNEL_BITS-1:0]       req_blue_in,
   input  logic [CHANNEL_BITS-1:0]       req_alpha_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CHANNEL_BITS-1:0]       rsp_red_out,
   output logic [CHANNEL_BITS-1:0]       rsp_green_out,
   output logic [CHANNEL_BITS-1:0]       rsp_blue_out,
   output logic [CHANNEL_BITS-1:0]       rsp_alpha_out,
   input  logic                          csr_wr_en,
   input  logic [hrp_pkg::HUE_W-1:0]     csr_wr_data
);

   `include "hue_rotate_pixel_macros.svh"

   localparam int QW     = hrp_pkg::QUO_W;
   localparam int STAGES = QW + 7;
   localparam int NUM_W  = CHANNEL_BITS + hrp_pkg::FIX_BITS;

   logic [STAGES-1:0]            vld_ff;
   logic                         en;
   logic [hrp_pkg::HUE_W-1:0]    offset_ff;

   assign en        = !vld_ff[STAGES-1] || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = vld_ff[STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_wr_en) begin
         offset_ff <= csr_wr_data;
      end
   end

   logic [CHANNEL_BITS-1:0]  v0, a0;
   hrp_pkg::hue_ctrl_type    ctrl0;
   logic [NUM_W-1:0]         s_num, h_num;
   logic [CHANNEL_BITS-1:0]  s_den, h_den;
   logic [QW-1:0]            s_quo, h_quo;

   hrp_hsv #(.CHANNEL_BITS(CHANNEL_BITS)) u_hsv (
      .clock    (clock),
      .en       (en),
      .red      (req_red_in),
      .green    (req_green_in),
      .blue     (req_blue_in),
      .alpha    (req_alpha_in),
      .v_ff     (v0),
      .alpha_ff (a0),
      .ctrl_ff  (ctrl0),
      .s_num_ff (s_num),
      .s_den_ff (s_den),
      .h_num_ff (h_num),
      .h_den_ff (h_den)
   );

   hrp_div #(.DEN_W(CHANNEL_BITS), .QUO_W(QW)) u_sat_div (
      .clock (clock),
      .en    (en),
      .num   (s_num),
      .den   (s_den),
      .quo   (s_quo)
   );

   hrp_div #(.DEN_W(CHANNEL_BITS), .QUO_W(QW)) u_hue_div (
      .clock (clock),
      .en    (en),
      .num   (h_num),
      .den   (h_den),
      .quo   (h_quo)
   );

   // pixel side data rides alongside the dividers
   logic [CHANNEL_BITS-1:0]  v_dly_ff    [QW];
   logic [CHANNEL_BITS-1:0]  a_dly_ff    [QW];
   hrp_pkg::hue_ctrl_type    ctrl_dly_ff [QW];

   always_ff @(posedge clock) begin
      if (en) begin
         v_dly_ff[0]    <= v0;
         a_dly_ff[0]    <= a0;
         ctrl_dly_ff[0] <= ctrl0;
         for (int i = 1; i < QW; i++) begin
            v_dly_ff[i]    <= v_dly_ff[i-1];
            a_dly_ff[i]    <= a_dly_ff[i-1];
            ctrl_dly_ff[i] <= ctrl_dly_ff[i-1];
         end
      end
   end

   hrp_rgb #(.CHANNEL_BITS(CHANNEL_BITS)) u_rgb (
      .clock      (clock),
      .en         (en),
      .hue_offset (offset_ff),
      .v          (v_dly_ff[QW-1]),
      .alpha      (a_dly_ff[QW-1]),
      .ctrl       (ctrl_dly_ff[QW-1]),
      .s_quo      (s_quo),
      .h_quo      (h_quo),
      .red_ff     (rsp_red_out),
      .green_ff   (rsp_green_out),
      .blue_ff    (rsp_blue_out),
      .alpha_ff   (rsp_alpha_out)
   );

   `HRP_ASSERT_NEXT(a_stall_freezes_pipe, rsp_valid && rsp_stall, $stable(vld_ff),
                    "pipeline moved while the result was stalled")
   `HRP_ASSERT_NEXT(a_last_stage_drains, en && vld_ff[STAGES-2], rsp_valid,
                    "item lost before the output register")
   `HRP_ASSERT_NOW(a_empty_pipe_ready, vld_ff == '0, !rsp_valid && !req_stall,
                   "empty pipeline not accepting")

endmodule
